// ----- design/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; no dependencies.
package spq_pkg;

	localparam int DATA_W           = 32;
	localparam int OP_W             = 2;
	localparam int STATUS_W         = 2;
	localparam int COUNT_W          = 5;
	localparam int DEFAULT_CAPACITY = 16;
	localparam int IN_TDATA_W       = 64;
	localparam int OUT_TDATA_W      = 72;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                     valid;
		logic        [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] prio;
	} cell_t;

	typedef struct packed {
		logic ins;
		logic del;
	} ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and shifts it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  spq_pkg::ctrl_t ctrl,
	input  spq_pkg::cell_t ins_entry,
	input  spq_pkg::cell_t left,
	input  logic           left_stay,
	input  spq_pkg::cell_t right,
	output spq_pkg::cell_t entry,
	output logic           stay
);
	import spq_pkg::*;

	cell_t entry_q;
	cell_t entry_nxt;

	// entries of equal priority keep their place ahead of the new one
	assign stay  = entry_q.valid && (entry_q.prio >= ins_entry.prio);
	assign entry = entry_q;

	always_comb begin
		entry_nxt = entry_q;
		if (ctrl.ins) begin
			if (!stay) begin
				if (left_stay) begin
					entry_nxt = ins_entry;
				end else begin
					entry_nxt = left;
				end
			end
		end else if (ctrl.del) begin
			entry_nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_nxt;
		end
	end

endmodule

// ----- design/sorted_priority_queue.sv -----
// Sorted priority queue: a row of CAPACITY cells kept in priority order.
// The result beat for an accepted beat appears on the output in the cycle after it is accepted.
// Throughput: one beat per cycle while the output is not stalled; each cell shifts, loads or holds.
// Reset: arst_n clears the cell valid bits, the fill count and the output valid flag.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] data_in, [63:32] prio_in
	input  logic [spq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [spq_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] data_out, [63:32] prio_out, [68:64] count, [71:69] zero
	output logic [spq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// [1:0] status
	output logic [spq_pkg::STATUS_W-1:0]       m_axis_tuser
);
	import spq_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CAPACITY);
	localparam int PAD_W = OUT_TDATA_W - 2 * DATA_W - COUNT_W;

	logic                  accept;
	logic [OP_W-1:0]       op;
	logic                  is_empty;
	logic                  is_full;
	ctrl_t                 ctrl;
	cell_t                 ins_entry;
	cell_t                 entry_vec [CAPACITY];
	logic  [CAPACITY-1:0]  stay_vec;

	logic [FILL_W-1:0]          fill_q;
	logic [FILL_W-1:0]          fill_nxt;
	logic [FILL_W+COUNT_W-1:0]  fill_ext;
	logic [STATUS_W-1:0]        status_nxt;
	logic [DATA_W-1:0]          dout_nxt;
	logic [DATA_W-1:0]          pout_nxt;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [DATA_W-1:0]     out_data_q;
	logic [DATA_W-1:0]     out_prio_q;
	logic [COUNT_W-1:0]    out_count_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op            = s_axis_tuser;
	assign is_empty      = (fill_q == '0);
	assign is_full       = (fill_q == FULL_FILL);

	assign ins_entry.valid = 1'b1;
	assign ins_entry.data  = s_axis_tdata[DATA_W-1:0];
	assign ins_entry.prio  = s_axis_tdata[2*DATA_W-1:DATA_W];

	assign ctrl.ins = accept && (op == OP_INSERT) && !is_full;
	assign ctrl.del = accept && (op == OP_DELETE) && !is_empty;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			cell_t left_e;
			cell_t right_e;
			logic  left_s;

			if (i == 0) begin : g_head
				assign left_e = '0;
				assign left_s = 1'b1;
			end else begin : g_body
				assign left_e = entry_vec[i-1];
				assign left_s = stay_vec[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign right_e = '0;
			end else begin : g_mid
				assign right_e = entry_vec[i+1];
			end

			spq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.ins_entry (ins_entry),
				.left      (left_e),
				.left_stay (left_s),
				.right     (right_e),
				.entry     (entry_vec[i]),
				.stay      (stay_vec[i])
			);
		end
	endgenerate

	always_comb begin
		fill_nxt   = fill_q;
		status_nxt = ST_OK;
		dout_nxt   = '0;
		pout_nxt   = '0;
		case (op)
			OP_INSERT: begin
				if (is_full) begin
					status_nxt = ST_FULL;
				end else begin
					fill_nxt = fill_q + 1'b1;
				end
			end
			OP_DELETE, OP_PEEK: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					dout_nxt = entry_vec[0].data;
					pout_nxt = entry_vec[0].prio;
					if (op == OP_DELETE) begin
						fill_nxt = fill_q - 1'b1;
					end
				end
			end
			default: begin
				fill_nxt = fill_q;
			end
		endcase
	end

	assign fill_ext = {{COUNT_W{1'b0}}, fill_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_nxt;
			out_data_q   <= dout_nxt;
			out_prio_q   <= pout_nxt;
			out_count_q  <= fill_ext[COUNT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_count_q, out_prio_q, out_data_q};

	// head cell is occupied exactly when the queue holds something
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) == !entry_vec[0].valid)
		else $error("head cell valid disagrees with fill count");

	// tail cell is occupied exactly when the queue is full
	a_tail_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == FULL_FILL) == entry_vec[CAPACITY-1].valid)
		else $error("tail cell valid disagrees with fill count");

	// a taken insert grows the queue by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("insert did not grow fill count");

	// an empty report carries no entry
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_EMPTY)) |->
		((out_data_q == '0) && (out_prio_q == '0) && (out_count_q == '0)))
		else $error("empty result carries nonzero payload");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for sorted_priority_queue: random and directed
// insert/delete/peek beats, checked against an in-bench sorted-array predictor.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb;
	import spq_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int QUEUE_DEPTH = DEFAULT_CAPACITY;
	localparam int ITEM_TARGET = 1950;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic signed [DATA_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic [DATA_W-1:0]        data;
		logic signed [DATA_W-1:0] prio;
	} request_t;

	typedef struct {
		logic [STATUS_W-1:0]      status;
		logic [DATA_W-1:0]        data;
		logic signed [DATA_W-1:0] prio;
		logic [COUNT_W-1:0]       count;
	} answer_t;

	typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_e;
	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [IN_TDATA_W-1:0]      s_axis_tdata;
	logic [OP_W-1:0]            s_axis_tuser;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [OUT_TDATA_W-1:0]     m_axis_tdata;
	logic [STATUS_W-1:0]        m_axis_tuser;

	sorted_priority_queue uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// shadow copy of the sorted entries, front at index 0
	logic [DATA_W-1:0]        shadow_data [QUEUE_DEPTH];
	logic signed [DATA_W-1:0] shadow_prio [QUEUE_DEPTH];
	int                       shadow_fill;

	request_t requests_pending[$];
	answer_t  answers_due[$];
	request_t next_req;
	answer_t  want;

	int  cycles;
	int  error_count;
	int  beats_in;
	int  beats_out;
	int  n_insert, n_delete, n_peek, n_unused, n_full_drop, n_empty_hit, peak_fill;
	bit  beat_taken;
	int  burst_left;
	int  gap_left;
	int  rx_left;
	rx_mode_e rx_mode;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Predicts the answer to one request and updates the shadow queue.
	function automatic answer_t serve_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
			logic signed [DATA_W-1:0] prio);
		answer_t ans;
		int k;
		ans.status = ST_OK;
		ans.data = '0;
		ans.prio = '0;
		if (op == OP_INSERT) begin
			n_insert++;
			if (shadow_fill >= QUEUE_DEPTH) begin
				ans.status = ST_FULL;
				n_full_drop++;
			end else begin
				// ties keep arrival order: new entry goes behind equal priorities
				k = shadow_fill;
				while (k > 0 && shadow_prio[k-1] < prio) begin
					shadow_data[k] = shadow_data[k-1];
					shadow_prio[k] = shadow_prio[k-1];
					k--;
				end
				shadow_data[k] = data;
				shadow_prio[k] = prio;
				shadow_fill++;
			end
		end else if (op == OP_DELETE || op == OP_PEEK) begin
			if (op == OP_DELETE)
				n_delete++;
			else
				n_peek++;
			if (shadow_fill == 0) begin
				ans.status = ST_EMPTY;
				n_empty_hit++;
			end else begin
				ans.data = shadow_data[0];
				ans.prio = shadow_prio[0];
				if (op == OP_DELETE) begin
					for (k = 0; k + 1 < shadow_fill; k++) begin
						shadow_data[k] = shadow_data[k+1];
						shadow_prio[k] = shadow_prio[k+1];
					end
					shadow_fill--;
				end
			end
		end else begin
			n_unused++;
		end
		if (shadow_fill > peak_fill)
			peak_fill = shadow_fill;
		ans.count = shadow_fill[COUNT_W-1:0];
		return ans;
	endfunction

	function automatic void add_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
			logic signed [DATA_W-1:0] prio);
		request_t r;
		r.op = op;
		r.data = data;
		r.prio = prio;
		requests_pending.push_back(r);
	endfunction

	// sender: bursts of beats separated by random gaps
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || beat_taken)) begin
			beat_taken = 1'b0;
			if (gap_left > 0 || requests_pending.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= {$urandom, $urandom};
				s_axis_tuser <= OP_W'($urandom);
			end else begin
				next_req = requests_pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {next_req.prio, next_req.data};
				s_axis_tuser <= next_req.op;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// receiver: picks a new random stall pattern whenever the current run runs out
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
				default:   m_axis_tready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	// accepted input beats feed the predictor; output beats are checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (s_axis_tvalid && s_axis_tready) begin
				answers_due.push_back(serve_request(s_axis_tuser, s_axis_tdata[31:0],
					s_axis_tdata[63:32]));
				beat_taken = 1'b1;
				beats_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				beats_out++;
				if (answers_due.size() == 0) begin
					error_count++;
					$error("result beat with no request outstanding: tdata %h tuser %h",
						m_axis_tdata, m_axis_tuser);
				end else begin
					want = answers_due.pop_front();
					if (m_axis_tuser !== want.status) begin
						error_count++;
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					end
					if (m_axis_tdata[31:0] !== want.data) begin
						error_count++;
						$error("data_out: expected %h, got %h", want.data, m_axis_tdata[31:0]);
					end
					if (m_axis_tdata[63:32] !== want.prio) begin
						error_count++;
						$error("prio_out: expected %h, got %h", want.prio, m_axis_tdata[63:32]);
					end
					if (m_axis_tdata[68:64] !== want.count) begin
						error_count++;
						$error("count: expected %0d, got %0d", want.count, m_axis_tdata[68:64]);
					end
					if (m_axis_tdata[71:69] !== 3'b000) begin
						error_count++;
						$error("pad bits: expected 0, got %b", m_axis_tdata[71:69]);
					end
				end
			end
		end
	end

	initial begin
		int n;
		int seg_left;
		op_mix_e mix;
		int roll;
		logic [OP_W-1:0] op;
		logic signed [DATA_W-1:0] prio;
		logic signed [DATA_W-1:0] edge_prios [16];

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_INSERT;
		m_axis_tready = 1'b0;
		shadow_fill = 0;
		beat_taken = 1'b0;
		burst_left = 1;
		gap_left = 0;
		rx_left = 0;
		rx_mode = RX_OPEN;
		cycles = 0;
		error_count = 0;
		beats_in = 0;
		beats_out = 0;
		n_insert = 0; n_delete = 0; n_peek = 0; n_unused = 0;
		n_full_drop = 0; n_empty_hit = 0; peak_fill = 0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			shadow_data[i] = '0;
			shadow_prio[i] = '0;
		end

		// directed: empty queue, fill with extremes and ties, overflow, then read back
		add_request(OP_PEEK, '0, '0);
		add_request(OP_DELETE, '0, '0);
		add_request(OP_UNUSED, '1, -1);
		edge_prios = '{PRIO_MAX, PRIO_MIN, 0, 0, -1, 1, PRIO_MAX, PRIO_MIN,
			0, -1, 5, 5, -5, 100, PRIO_MAX, 0};
		for (int i = 0; i < QUEUE_DEPTH; i++)
			add_request(OP_INSERT, (i == 0) ? 32'h7FFF_FFFF : (i == 1) ? 32'h8000_0000 :
				(i == 2) ? 32'h0 : (i == 3) ? 32'hFFFF_FFFF : 32'h100 + i, edge_prios[i]);
		add_request(OP_INSERT, 32'hDEAD_0001, PRIO_MAX);
		add_request(OP_UNUSED, '0, '0);
		add_request(OP_PEEK, '0, '0);
		add_request(OP_DELETE, '0, '0);

		// random: segments that lean toward filling, draining or neither
		n = requests_pending.size();
		seg_left = 0;
		mix = MIX_EVEN;
		while (n < ITEM_TARGET) begin
			if (seg_left == 0) begin
				mix = op_mix_e'($urandom_range(0, 2));
				seg_left = $urandom_range(10, 80);
			end
			seg_left--;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = OP_UNUSED;
			else if (mix == MIX_FILL)
				op = (roll < 75) ? OP_INSERT : (roll < 90) ? OP_DELETE : OP_PEEK;
			else if (mix == MIX_DRAIN)
				op = (roll < 25) ? OP_INSERT : (roll < 85) ? OP_DELETE : OP_PEEK;
			else
				op = (roll < 48) ? OP_INSERT : (roll < 85) ? OP_DELETE : OP_PEEK;
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 4))
						0: prio = PRIO_MIN;
						1: prio = PRIO_MAX;
						2: prio = -1;
						3: prio = 0;
						default: prio = 1;
					endcase
				end
				1, 2, 3, 4: prio = $signed($urandom_range(0, 6)) - 3;
				5, 6: prio = $signed($urandom_range(0, 255)) - 128;
				default: prio = $urandom;
			endcase
			add_request(op, $urandom, prio);
			n++;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while ((requests_pending.size() != 0 || s_axis_tvalid || answers_due.size() != 0)
				&& cycles < CYCLE_LIMIT)
			@(posedge clk);
		if (cycles < CYCLE_LIMIT)
			repeat (20) @(posedge clk);
		else begin
			error_count++;
			$error("timed out after %0d cycles with %0d results outstanding",
				cycles, answers_due.size());
		end

		$display("covered %0d beats in, %0d out: %0d inserts (%0d dropped full), %0d deletes,",
			beats_in, beats_out, n_insert, n_full_drop, n_delete);
		$display("%0d peeks, %0d unused ops, %0d empty-queue hits, peak occupancy %0d",
			n_peek, n_unused, n_empty_hit, peak_fill);
		if (error_count == 0 && answers_due.size() == 0)
			$display("sorted_priority_queue regression: pass");
		else
			$display("sorted_priority_queue regression: fail");
		$finish;
	end

endmodule
